FILE: rtl/dmp_pkg.sv
// shared constants for the multiple-path detector
// no dependencies; imported by the detector core

package dmp_pkg;

    // node capacity of the adjacency store
    localparam int NODES     = 64;
    localparam int NODE_W    = $clog2(NODES);
    localparam int COUNT_W   = NODE_W + 1;

    typedef logic [1:0] t_cmd;

    localparam t_cmd CMD_CLEAR = 2'd0;
    localparam t_cmd CMD_EDGE  = 2'd1;
    localparam t_cmd CMD_EVAL  = 2'd2;

    typedef logic [NODES-1:0] t_row;

endpackage

FILE: rtl/dmp_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies; used for the adjacency rows of the detector core

module dmp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/dag_multiple_path_detector_core.sv
// Multiple-path detector for a directed graph of up to 64 nodes. Edges are kept as
// adjacency rows in a ram; a clear command empties the graph by resetting the row
// valid flags (each row carries one) and a set-edge command reads the row, then
// writes it back. An evaluate command walks every source s below node_count and relaxes
// walk counts, saturated at two, one adjacency row read per cycle; a source takes up
// to n relaxation steps for n nodes in use and stops early when it runs out of
// reachable nodes, and the evaluate ends at the first source that raises the flag.
// The block accepts no item while it is busy; a finished flag waits in the output
// register and does not block the next transfer. node_count may be written only
// while the block is idle.
// depends on dmp_pkg and dmp_ram

module dag_multiple_path_detector_core
    import dmp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // item channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_command,
    input  logic [5:0] i_from_node,
    input  logic [5:0] i_to_node,
    // result channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_has_multiple_paths,
    // node_count register write
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [6:0] i_cfg_data
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_EDGE_RD = 3'd1;
    localparam logic [2:0] ST_EDGE_WR = 3'd2;
    localparam logic [2:0] ST_SRC     = 3'd3;
    localparam logic [2:0] ST_SCAN    = 3'd4;
    localparam logic [2:0] ST_STEP    = 3'd5;
    localparam logic [2:0] ST_DONE    = 3'd6;

    logic [2:0]         r_state;
    logic [6:0]         r_node_count;
    logic [NODES-1:0]   r_row_valid;
    logic [NODE_W-1:0]  r_from;
    logic [NODE_W-1:0]  r_to;

    logic [COUNT_W-1:0] r_nodes;
    t_row               r_mask;
    logic [COUNT_W-1:0] r_src;
    logic [COUNT_W-1:0] r_step;
    logic [COUNT_W-1:0] r_u;
    logic [NODE_W-1:0]  r_rd_u;
    logic               r_rd_pend;
    t_row               r_cur1;
    t_row               r_cur2;
    t_row               r_tot1;
    t_row               r_tot2;
    t_row               r_once;
    t_row               r_twice;
    logic               r_flag;

    logic               r_out_valid;
    logic               r_out_flag;

    logic [COUNT_W-1:0] lim_nodes;
    t_row               lim_mask;
    logic               accept;
    logic               rd_en;
    logic [NODE_W-1:0]  rd_addr;
    t_row               rd_data;
    t_row               row;
    t_row               n_once;
    t_row               n_twice;
    t_row               n_tot1;
    t_row               n_tot2;
    t_row               src_bit;
    logic               issue;
    logic [COUNT_W-1:0] step_inc;
    logic               hit;

    assign accept = i_valid && (r_state == ST_IDLE);

    // node limit and its node mask, taken at the start of an evaluate
    always_comb begin
        lim_nodes = (r_node_count > COUNT_W'(NODES)) ? COUNT_W'(NODES)
                                                      : COUNT_W'(r_node_count);
        for (int i = 0; i < NODES; i++) begin
            lim_mask[i] = COUNT_W'(i) < lim_nodes;
        end
    end

    assign issue   = (r_state == ST_SCAN) && (r_u < r_nodes);
    assign rd_en   = (r_state == ST_EDGE_RD) || issue;
    assign rd_addr = (r_state == ST_EDGE_RD) ? r_from : r_u[NODE_W-1:0];

    dmp_ram #(
        .WIDTH (NODES),
        .DEPTH (NODES)
    ) u_adj (
        .i_clk     (i_clk),
        .i_wr_en   (r_state == ST_EDGE_WR),
        .i_wr_addr (r_from),
        .i_wr_data (row | (t_row'(1) << r_to)),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // a row never written since the last clear reads as empty
    always_comb begin
        if (r_state == ST_EDGE_WR) begin
            row = r_row_valid[r_from] ? rd_data : '0;
        end else begin
            row = (r_row_valid[r_rd_u] ? rd_data : '0) & r_mask;
        end
    end

    // one relaxation of the walk counts through the row just read
    always_comb begin
        n_once  = r_once;
        n_twice = r_twice;
        if (r_rd_pend && r_cur1[r_rd_u]) begin
            n_twice = r_twice | (r_cur2[r_rd_u] ? row : (r_once & row));
            n_once  = r_once | row;
        end
    end

    assign src_bit  = t_row'(1) << r_src[NODE_W-1:0];
    assign n_tot2   = r_tot2 | (r_tot1 & r_once) | r_twice;
    assign n_tot1   = r_tot1 | r_once;
    assign step_inc = r_step + COUNT_W'(1);
    assign hit      = |(n_tot2 & r_mask & ~src_bit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_node_count <= 7'd1;
            r_row_valid  <= '0;
            r_out_valid  <= 1'b0;
            r_rd_pend    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_node_count <= i_cfg_data;
            end
            // the done state loads the output register itself
            if (r_out_valid && !i_stall && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_from <= i_from_node;
                        r_to   <= i_to_node;
                        case (i_command)
                            CMD_CLEAR: r_row_valid <= '0;
                            CMD_EDGE:  r_state <= ST_EDGE_RD;
                            CMD_EVAL: begin
                                r_nodes <= lim_nodes;
                                r_mask  <= lim_mask;
                                r_src   <= '0;
                                r_flag  <= 1'b0;
                                r_state <= ST_SRC;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_EDGE_RD: r_state <= ST_EDGE_WR;
                ST_EDGE_WR: begin
                    r_row_valid[r_from] <= 1'b1;
                    r_state             <= ST_IDLE;
                end
                ST_SRC: begin
                    if (r_src >= r_nodes) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_cur1    <= src_bit;
                        r_cur2    <= '0;
                        r_tot1    <= '0;
                        r_tot2    <= '0;
                        r_once    <= '0;
                        r_twice   <= '0;
                        r_step    <= '0;
                        r_u       <= '0;
                        r_rd_pend <= 1'b0;
                        r_state   <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    r_once    <= n_once;
                    r_twice   <= n_twice;
                    r_rd_pend <= issue;
                    if (issue) begin
                        r_rd_u <= r_u[NODE_W-1:0];
                        r_u    <= r_u + COUNT_W'(1);
                    end else if (!r_rd_pend) begin
                        r_state <= ST_STEP;
                    end
                end
                ST_STEP: begin
                    r_cur1 <= r_once;
                    r_cur2 <= r_twice;
                    r_tot1 <= n_tot1;
                    r_tot2 <= n_tot2;
                    r_step <= step_inc;
                    if ((r_once == '0) || (step_inc == r_nodes)) begin
                        // source finished
                        if (hit) begin
                            r_flag  <= 1'b1;
                            r_state <= ST_DONE;
                        end else begin
                            r_src   <= r_src + COUNT_W'(1);
                            r_state <= ST_SRC;
                        end
                    end else begin
                        r_once  <= '0;
                        r_twice <= '0;
                        r_u     <= '0;
                        r_state <= ST_SCAN;
                    end
                end
                ST_DONE: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_flag  <= r_flag;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_stall              = (r_state != ST_IDLE);
    assign o_valid              = r_out_valid;
    assign o_has_multiple_paths = r_out_flag;
    assign o_cfg_ready          = 1'b1;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// self-checking bench for dag_multiple_path_detector_core: clear, set-edge and evaluate commands
// with random idling on both sides; depends on dmp_pkg and the detector core

module tb;
    import dmp_pkg::*;

    localparam t_cmd CMD_UNUSED  = 2'd3;
    localparam int   HOLD_CYCLES = 800;

    typedef struct packed {
        t_cmd              cmd;
        logic [NODE_W-1:0] src;
        logic [NODE_W-1:0] dst;
    } t_graph_op;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [1:0] i_command = CMD_CLEAR;
    logic [5:0] i_from_node = '0;
    logic [5:0] i_to_node = '0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic       o_has_multiple_paths;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [6:0] i_cfg_data = '0;

    // predictor state
    t_row       graph_rows [NODES];
    logic [6:0] node_cfg = 7'd1;

    t_graph_op  op_queue [$];
    bit         flag_expect [$];
    t_graph_op  cur_op;
    bit         want;
    bit         quiet = 1'b0;
    logic       hold_kick = 1'b0;
    int         hold_left;
    int         gap_left;
    int         stall_left;
    int         ops_queued;
    int         ops_taken;
    int         evals_sent;
    int         results_seen;
    int         flags_high;
    int         errors;

    dag_multiple_path_detector_core dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_command            (i_command),
        .i_from_node          (i_from_node),
        .i_to_node            (i_to_node),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_has_multiple_paths (o_has_multiple_paths),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_data           (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // saturated walk counting from every source in use; nodes at or above the count are masked
    function automatic bit predict_multi_path();
        int   n, s, k, u;
        t_row in_use, reach1, reach2, seen1, seen2, once, twice, row;
        bit   found;
        n = (node_cfg > NODES) ? NODES : int'(node_cfg);
        in_use = (n >= NODES) ? '1 : (t_row'(1) << n) - t_row'(1);
        found = 1'b0;
        for (s = 0; s < n && !found; s++) begin
            reach1 = t_row'(1) << s;
            reach2 = '0;
            seen1  = '0;
            seen2  = '0;
            for (k = 0; k < n; k++) begin
                once  = '0;
                twice = '0;
                for (u = 0; u < n; u++) begin
                    if (reach1[u]) begin
                        row = graph_rows[u] & in_use;
                        twice |= reach2[u] ? row : (once & row);
                        once  |= row;
                    end
                end
                reach1 = once;
                reach2 = twice;
                seen2 |= (seen1 & reach1) | reach2;
                seen1 |= reach1;
                if (reach1 == '0)
                    break;
            end
            found = (seen2 & in_use & ~(t_row'(1) << s)) != '0;
        end
        return found;
    endfunction

    task automatic queue_op(input t_cmd cmd, input int a, input int b);
        t_graph_op op;
        op.cmd = cmd;
        op.src = 6'(a);
        op.dst = 6'(b);
        op_queue.push_back(op);
        ops_queued++;
    endtask

    // mostly clear, a batch of edges, evaluate; the rest stray commands on any node
    task automatic queue_random_run(input int n, input bit acyclic);
        int edges, a, b, j;
        if (acyclic || $urandom_range(0, 9) < 7) begin
            if (acyclic || $urandom_range(0, 3) != 0)
                queue_op(CMD_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63));
            edges = $urandom_range(1, acyclic ? 6 : n + 2);
            for (j = 0; j < edges; j++) begin
                if (acyclic) begin
                    a = $urandom_range(0, n - 2);
                    b = $urandom_range(a + 1, n - 1);
                end else begin
                    a = $urandom_range(0, n - 1);
                    b = $urandom_range(0, n - 1);
                end
                queue_op(CMD_EDGE, a, b);
            end
            queue_op(CMD_EVAL, $urandom_range(0, 63), $urandom_range(0, 63));
        end else begin
            repeat ($urandom_range(1, 4))
                queue_op(t_cmd'($urandom_range(CMD_CLEAR, CMD_UNUSED)),
                         $urandom_range(0, 63), $urandom_range(0, 63));
        end
    endtask

    // wait for every transfer and every flag, then let any edge write finish
    task automatic settle();
        while (ops_taken != ops_queued || flag_expect.size() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_node_count(input logic [6:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        node_cfg = value;
        @(negedge i_clk);
    endtask

    // command driver and input-side predictor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            gap_left = 0;
        end else begin
            if (i_valid && !o_stall) begin
                case (cur_op.cmd)
                    CMD_CLEAR: foreach (graph_rows[r]) graph_rows[r] = '0;
                    CMD_EDGE:  graph_rows[cur_op.src][cur_op.dst] = 1'b1;
                    CMD_EVAL: begin
                        flag_expect.push_back(predict_multi_path());
                        evals_sent++;
                    end
                    default: ;
                endcase
                ops_taken++;
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (op_queue.size() > 0) begin
                    cur_op = op_queue.pop_front();
                    i_command   <= cur_op.cmd;
                    i_from_node <= cur_op.src;
                    i_to_node   <= cur_op.dst;
                    i_valid     <= 1'b1;
                    if (!quiet && $urandom_range(0, 7) == 0)
                        gap_left = $urandom_range(1, 19);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // long result hold-off, timed on its own
    always @(posedge i_clk) begin
        if (!i_rst_n)
            hold_left <= 0;
        else if (hold_kick)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // result monitor and stall bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (flag_expect.size() == 0) begin
                    $display("%0t: result with none outstanding, expected nothing, got %0b",
                             $time, o_has_multiple_paths);
                    errors++;
                end else begin
                    want = flag_expect.pop_front();
                    if (o_has_multiple_paths !== want) begin
                        $display("%0t: multiple-path flag mismatch, expected %0b, got %0b",
                                 $time, want, o_has_multiple_paths);
                        errors++;
                    end
                end
                results_seen++;
                if (o_has_multiple_paths === 1'b1)
                    flags_high++;
            end
            if (stall_left > 0)
                stall_left--;
            else if (!quiet && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 19);
            i_stall <= (stall_left > 0) || (hold_left != 0);
        end
    end

    initial begin : stimulus
        int phase_nodes [7] = '{3, 2, 8, 12, 64, 0, 7};
        int p, nodes, start;

        foreach (graph_rows[r]) graph_rows[r] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // single node after reset: a self loop alone must not flag, unused code ignored
        queue_op(CMD_EDGE, 0, 0);
        queue_op(CMD_EVAL, 63, 63);
        queue_op(CMD_UNUSED, 63, 0);
        settle();

        // diamond, empty graph, edge past the node count, two-node cycle
        write_node_count(7'd4);
        queue_op(CMD_CLEAR, 0, 0);
        queue_op(CMD_EDGE, 0, 1);
        queue_op(CMD_EDGE, 1, 3);
        queue_op(CMD_EDGE, 0, 2);
        queue_op(CMD_EDGE, 2, 3);
        queue_op(CMD_EVAL, 0, 0);
        queue_op(CMD_CLEAR, 63, 63);
        queue_op(CMD_EVAL, 0, 0);
        queue_op(CMD_EDGE, 0, 5);
        queue_op(CMD_EDGE, 3, 0);
        queue_op(CMD_EVAL, 0, 0);
        queue_op(CMD_EDGE, 1, 2);
        queue_op(CMD_EDGE, 2, 1);
        queue_op(CMD_EVAL, 0, 0);
        settle();

        // no nodes in use
        write_node_count(7'd0);
        queue_op(CMD_EVAL, 0, 0);
        settle();

        // count beyond capacity clamps to the full graph; diamond on the top node
        write_node_count(7'h7F);
        queue_op(CMD_CLEAR, 0, 0);
        queue_op(CMD_EDGE, 0, 63);
        queue_op(CMD_EDGE, 63, 62);
        queue_op(CMD_EDGE, 0, 62);
        queue_op(CMD_EVAL, 0, 0);
        settle();

        write_node_count(7'(NODES));
        queue_op(CMD_CLEAR, 0, 0);
        queue_op(CMD_EVAL, 0, 0);

        for (p = 0; p < 7; p++) begin
            settle();
            if (p == 6)
                quiet = 1'b1;
            nodes = (p == 5) ? $urandom_range(2, 10) : phase_nodes[p];
            write_node_count(7'(nodes));
            if (p == 0) begin
                @(posedge i_clk);
                hold_kick <= 1'b1;
                @(posedge i_clk);
                hold_kick <= 1'b0;
                @(negedge i_clk);
            end
            start = ops_queued;
            // full-size graphs stay acyclic and sparse to keep evaluation short
            if (nodes == NODES)
                repeat (3) queue_random_run(nodes, 1'b1);
            else
                while (ops_queued - start < 15)
                    queue_random_run(nodes, 1'b0);
        end

        settle();
        repeat (200) @(posedge i_clk);

        $display("covered %0d commands, %0d evaluations, %0d flags checked, %0d raised",
                 ops_taken, evals_sent, results_seen, flags_high);
        $display("node counts 0, 1 to 12, 64 and clamped 127, with a long result hold-off");
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #30_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/dmp_pkg.sv
rtl/dmp_ram.sv
rtl/dag_multiple_path_detector_core.sv
tb/tb.sv
